/* rtl/gdzn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdzn_pkg
// Shared widths, constants and register indexes of the gamepad dead zone
// normaliser.
// ----------------------------------------------------------------------------
package gdzn_pkg;

	localparam int AXIS_W   = 16;
	localparam int ROOT_W   = 16;
	localparam int DZ_W     = 15;
	localparam int TRIG_W   = 8;
	localparam int QUO_W    = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [DZ_W-1:0]   FULL_SCALE  = 15'd32767;
	localparam logic [TRIG_W-1:0] TRIGGER_MAX = 8'd255;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_THR = 2'd2;

	localparam int LEFT_DZ_RST_I  = 7849;
	localparam int RIGHT_DZ_RST_I = 8689;

	localparam logic [DZ_W-1:0]     LEFT_DZ_RST     = DZ_W'(LEFT_DZ_RST_I);
	localparam logic [DZ_W-1:0]     RIGHT_DZ_RST    = DZ_W'(RIGHT_DZ_RST_I);
	localparam logic [2*DZ_W-1:0]   LEFT_DZ_SQ_RST  = (2*DZ_W)'(LEFT_DZ_RST_I * LEFT_DZ_RST_I);
	localparam logic [2*DZ_W-1:0]   RIGHT_DZ_SQ_RST = (2*DZ_W)'(RIGHT_DZ_RST_I * RIGHT_DZ_RST_I);
	localparam logic [TRIG_W-1:0]   TRIG_THR_RST    = 8'd30;

endpackage
`default_nettype wire

/* rtl/gdzn_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdzn_isqrt
// Pipelined integer square root, rounded down: one root bit per stage,
// ROOT_W stages, a new radicand every cycle.
// ----------------------------------------------------------------------------
module gdzn_isqrt (
	input  wire logic                          clk,
	input  wire logic [2*gdzn_pkg::ROOT_W-1:0] rad,
	output logic      [gdzn_pkg::ROOT_W-1:0]   root
);
	import gdzn_pkg::*;

	localparam int REM_W = 2 * ROOT_W;
	localparam int EXT_W = REM_W + 2;

	logic [REM_W-1:0]  rem_w  [0:ROOT_W];
	logic [ROOT_W-1:0] root_w [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];

	assign rem_w[0]  = rad;
	assign root_w[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic [EXT_W-1:0] delta;
		logic             ge;

		// (r + 2^B)^2 - r^2
		assign delta = (EXT_W'(root_w[k]) << (B + 1)) + (EXT_W'(1) << (2 * B));
		assign ge    = EXT_W'(rem_w[k]) >= delta;

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? REM_W'(EXT_W'(rem_w[k]) - delta) : rem_w[k];
			root_s[k] <= ge ? (root_w[k] | (ROOT_W'(1) << B)) : root_w[k];
		end

		assign rem_w[k+1]  = rem_s[k];
		assign root_w[k+1] = root_s[k];
	end

	assign root = root_w[ROOT_W];

endmodule
`default_nettype wire

/* rtl/gdzn_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdzn_div
// Pipelined restoring divider: one quotient bit per stage. The quotient must
// fit in QUO_W bits; a new division enters every cycle.
// ----------------------------------------------------------------------------
module gdzn_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 31,
	parameter int QUO_W = 15
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);
	localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_w [0:QUO_W];
	logic [DEN_W-1:0] den_w [0:QUO_W];
	logic [QUO_W-1:0] quo_w [0:QUO_W];
	logic [NUM_W-1:0] rem_s [0:QUO_W-1];
	logic [DEN_W-1:0] den_s [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s [0:QUO_W-1];

	assign rem_w[0] = num;
	assign den_w[0] = den;
	assign quo_w[0] = '0;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [CMP_W-1:0] dsh;
		logic             ge;

		assign dsh = CMP_W'(den_w[k]) << B;
		assign ge  = CMP_W'(rem_w[k]) >= dsh;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? NUM_W'(CMP_W'(rem_w[k]) - dsh) : rem_w[k];
			den_s[k] <= den_w[k];
			quo_s[k] <= ge ? (quo_w[k] | (QUO_W'(1) << B)) : quo_w[k];
		end

		assign rem_w[k+1] = rem_s[k];
		assign den_w[k+1] = den_s[k];
		assign quo_w[k+1] = quo_s[k];
	end

	assign quo = quo_w[QUO_W];

endmodule
`default_nettype wire

/* rtl/gamepad_dead_zone_normalizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_dead_zone_normalizer
// Radial dead zone and rescale of both sticks, threshold and rescale of both
// triggers, one gamepad sample per clock.
//
//   channel   handshake          payload
//   input     start / busy       left/right stick x/y, left/right trigger raw
//   result    done (one cycle)   left/right out x/y, left/right trigger out
//   config    cfg_we             cfg_addr, cfg_wdata
//
// A sample passes from start to done through the registered pipeline; one sample is
// taken per cycle. The pipeline holds the 16-stage square root and the 15-stage dividers.
// busy is always low. done pulses for one cycle per sample; results are not
// held. Reset clears the pipeline valid bits and restores the register values.
// ----------------------------------------------------------------------------
module gamepad_dead_zone_normalizer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [gdzn_pkg::AXIS_W-1:0] left_stick_x,
	input  wire logic signed [gdzn_pkg::AXIS_W-1:0] left_stick_y,
	input  wire logic signed [gdzn_pkg::AXIS_W-1:0] right_stick_x,
	input  wire logic signed [gdzn_pkg::AXIS_W-1:0] right_stick_y,
	input  wire logic        [gdzn_pkg::TRIG_W-1:0] left_trigger_raw,
	input  wire logic        [gdzn_pkg::TRIG_W-1:0] right_trigger_raw,
	output logic                                   done,
	output logic signed      [gdzn_pkg::AXIS_W-1:0] left_out_x,
	output logic signed      [gdzn_pkg::AXIS_W-1:0] left_out_y,
	output logic signed      [gdzn_pkg::AXIS_W-1:0] right_out_x,
	output logic signed      [gdzn_pkg::AXIS_W-1:0] right_out_y,
	output logic             [gdzn_pkg::QUO_W-1:0]  left_trigger_out,
	output logic             [gdzn_pkg::QUO_W-1:0]  right_trigger_out,
	input  wire logic                              cfg_we,
	input  wire logic     [gdzn_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic          [gdzn_pkg::DZ_W-1:0] cfg_wdata
);
	import gdzn_pkg::*;

	localparam int LATENCY = 37;
	localparam int SUM_W   = 2 * AXIS_W;
	localparam int NUM_W   = 2 * DZ_W;
	localparam int DEN_W   = ROOT_W + DZ_W;
	localparam int PRD_W   = AXIS_W + NUM_W;
	localparam int TNUM_W  = TRIG_W + DZ_W;

	typedef struct packed {
		logic              valid;
		logic [AXIS_W-1:0] ax_l, ay_l, ax_r, ay_r;
		logic              sx_l, sy_l, sx_r, sy_r;
		logic              zero_l, zero_r;
		logic [TRIG_W-1:0] trig_l, trig_r;
	} smp_t;

	typedef struct packed {
		logic valid;
		logic sx_l, sy_l, sx_r, sy_r;
		logic zero_l, zero_r;
		logic tz_l, tz_r;
	} sgn_t;

	// configuration
	logic [DZ_W-1:0]   dz_l_q, dz_r_q;
	logic [NUM_W-1:0]  dzsq_l_q, dzsq_r_q;
	logic [TRIG_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_l_q   <= LEFT_DZ_RST;
			dz_r_q   <= RIGHT_DZ_RST;
			dzsq_l_q <= LEFT_DZ_SQ_RST;
			dzsq_r_q <= RIGHT_DZ_SQ_RST;
			thr_q    <= TRIG_THR_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LEFT_DZ: begin
					dz_l_q   <= cfg_wdata;
					dzsq_l_q <= NUM_W'(cfg_wdata) * NUM_W'(cfg_wdata);
				end
				REG_RIGHT_DZ: begin
					dz_r_q   <= cfg_wdata;
					dzsq_r_q <= NUM_W'(cfg_wdata) * NUM_W'(cfg_wdata);
				end
				REG_TRIG_THR: thr_q <= cfg_wdata[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: absolute values and signs
	smp_t smp_in, smp_s1, smp_s2, smp_s3, smp_s20;
	smp_t smp_sq_s [0:ROOT_W-1];

	always_comb begin
		smp_in        = '0;
		smp_in.valid  = start;
		smp_in.sx_l   = left_stick_x[AXIS_W-1];
		smp_in.sy_l   = left_stick_y[AXIS_W-1];
		smp_in.sx_r   = right_stick_x[AXIS_W-1];
		smp_in.sy_r   = right_stick_y[AXIS_W-1];
		smp_in.ax_l   = smp_in.sx_l ? AXIS_W'(~left_stick_x + 1'b1) : AXIS_W'(left_stick_x);
		smp_in.ay_l   = smp_in.sy_l ? AXIS_W'(~left_stick_y + 1'b1) : AXIS_W'(left_stick_y);
		smp_in.ax_r   = smp_in.sx_r ? AXIS_W'(~right_stick_x + 1'b1) : AXIS_W'(right_stick_x);
		smp_in.ay_r   = smp_in.sy_r ? AXIS_W'(~right_stick_y + 1'b1) : AXIS_W'(right_stick_y);
		smp_in.trig_l = left_trigger_raw;
		smp_in.trig_r = right_trigger_raw;
	end

	// stage 2: squares; stage 3: sums and dead zone test
	logic [SUM_W-1:0] sqx_l_s2, sqy_l_s2, sqx_r_s2, sqy_r_s2;
	logic [SUM_W-1:0] sum_l_s3, sum_r_s3;
	smp_t             smp_s3_d;

	always_comb begin
		smp_s3_d        = smp_s2;
		smp_s3_d.zero_l = (dz_l_q == FULL_SCALE) ||
			((sqx_l_s2 + sqy_l_s2) <= SUM_W'(dzsq_l_q));
		smp_s3_d.zero_r = (dz_r_q == FULL_SCALE) ||
			((sqx_r_s2 + sqy_r_s2) <= SUM_W'(dzsq_r_q));
	end

	// square roots
	logic [ROOT_W-1:0] m_l, m_r;

	gdzn_isqrt u_sqrt_l (.clk(clk), .rad(sum_l_s3), .root(m_l));
	gdzn_isqrt u_sqrt_r (.clk(clk), .rad(sum_r_s3), .root(m_r));

	// stage 20: numerator and denominator of the stick scale
	logic [DZ_W-1:0]  mc_l, mc_r;
	logic [NUM_W-1:0] num_l_s20, num_r_s20;
	logic [DEN_W-1:0] den_l_s20, den_r_s20;

	assign mc_l = (m_l > ROOT_W'(FULL_SCALE)) ? FULL_SCALE : m_l[DZ_W-1:0];
	assign mc_r = (m_r > ROOT_W'(FULL_SCALE)) ? FULL_SCALE : m_r[DZ_W-1:0];

	// stage 21: products and trigger terms
	logic [PRD_W-1:0]  px_l_s21, py_l_s21, px_r_s21, py_r_s21;
	logic [DEN_W-1:0]  den_l_s21, den_r_s21;
	logic [TNUM_W-1:0] tn_l_s21, tn_r_s21;
	logic [TRIG_W-1:0] td_l_s21, td_r_s21;
	sgn_t              sgn_s21, sgn_s21_d;
	sgn_t              sgn_dv_s [0:QUO_W-1];

	always_comb begin
		sgn_s21_d        = '0;
		sgn_s21_d.valid  = smp_s20.valid;
		sgn_s21_d.sx_l   = smp_s20.sx_l;
		sgn_s21_d.sy_l   = smp_s20.sy_l;
		sgn_s21_d.sx_r   = smp_s20.sx_r;
		sgn_s21_d.sy_r   = smp_s20.sy_r;
		sgn_s21_d.zero_l = smp_s20.zero_l;
		sgn_s21_d.zero_r = smp_s20.zero_r;
		sgn_s21_d.tz_l   = smp_s20.trig_l <= thr_q;
		sgn_s21_d.tz_r   = smp_s20.trig_r <= thr_q;
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1  <= '0;
			smp_s2  <= '0;
			smp_s3  <= '0;
			smp_s20 <= '0;
			sgn_s21 <= '0;
			for (int i = 0; i < ROOT_W; i++) smp_sq_s[i] <= '0;
			for (int i = 0; i < QUO_W; i++) sgn_dv_s[i] <= '0;
		end else begin
			smp_s1      <= smp_in;
			smp_s2      <= smp_s1;
			smp_s3      <= smp_s3_d;
			smp_sq_s[0] <= smp_s3;
			for (int i = 1; i < ROOT_W; i++) smp_sq_s[i] <= smp_sq_s[i-1];
			smp_s20     <= smp_sq_s[ROOT_W-1];
			sgn_s21     <= sgn_s21_d;
			sgn_dv_s[0] <= sgn_s21;
			for (int i = 1; i < QUO_W; i++) sgn_dv_s[i] <= sgn_dv_s[i-1];
		end
	end

	// datapath pipeline
	always_ff @(posedge clk) begin
		sqx_l_s2  <= SUM_W'(smp_s1.ax_l) * SUM_W'(smp_s1.ax_l);
		sqy_l_s2  <= SUM_W'(smp_s1.ay_l) * SUM_W'(smp_s1.ay_l);
		sqx_r_s2  <= SUM_W'(smp_s1.ax_r) * SUM_W'(smp_s1.ax_r);
		sqy_r_s2  <= SUM_W'(smp_s1.ay_r) * SUM_W'(smp_s1.ay_r);
		sum_l_s3  <= sqx_l_s2 + sqy_l_s2;
		sum_r_s3  <= sqx_r_s2 + sqy_r_s2;
		num_l_s20 <= NUM_W'(DZ_W'(mc_l - dz_l_q)) * NUM_W'(FULL_SCALE);
		num_r_s20 <= NUM_W'(DZ_W'(mc_r - dz_r_q)) * NUM_W'(FULL_SCALE);
		den_l_s20 <= DEN_W'(m_l) * DEN_W'(DZ_W'(FULL_SCALE - dz_l_q));
		den_r_s20 <= DEN_W'(m_r) * DEN_W'(DZ_W'(FULL_SCALE - dz_r_q));
		px_l_s21  <= PRD_W'(smp_s20.ax_l) * PRD_W'(num_l_s20);
		py_l_s21  <= PRD_W'(smp_s20.ay_l) * PRD_W'(num_l_s20);
		px_r_s21  <= PRD_W'(smp_s20.ax_r) * PRD_W'(num_r_s20);
		py_r_s21  <= PRD_W'(smp_s20.ay_r) * PRD_W'(num_r_s20);
		den_l_s21 <= den_l_s20;
		den_r_s21 <= den_r_s20;
		tn_l_s21  <= TNUM_W'(TRIG_W'(smp_s20.trig_l - thr_q)) * TNUM_W'(FULL_SCALE);
		tn_r_s21  <= TNUM_W'(TRIG_W'(smp_s20.trig_r - thr_q)) * TNUM_W'(FULL_SCALE);
		td_l_s21  <= TRIG_W'(TRIGGER_MAX - thr_q);
		td_r_s21  <= TRIG_W'(TRIGGER_MAX - thr_q);
	end

	// dividers
	logic [QUO_W-1:0] qx_l, qy_l, qx_r, qy_r, qt_l, qt_r;

	gdzn_div #(.NUM_W(PRD_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_xl (
		.clk(clk), .num(px_l_s21), .den(den_l_s21), .quo(qx_l));
	gdzn_div #(.NUM_W(PRD_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_yl (
		.clk(clk), .num(py_l_s21), .den(den_l_s21), .quo(qy_l));
	gdzn_div #(.NUM_W(PRD_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_xr (
		.clk(clk), .num(px_r_s21), .den(den_r_s21), .quo(qx_r));
	gdzn_div #(.NUM_W(PRD_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_yr (
		.clk(clk), .num(py_r_s21), .den(den_r_s21), .quo(qy_r));
	gdzn_div #(.NUM_W(TNUM_W), .DEN_W(TRIG_W), .QUO_W(QUO_W)) u_div_tl (
		.clk(clk), .num(tn_l_s21), .den(td_l_s21), .quo(qt_l));
	gdzn_div #(.NUM_W(TNUM_W), .DEN_W(TRIG_W), .QUO_W(QUO_W)) u_div_tr (
		.clk(clk), .num(tn_r_s21), .den(td_r_s21), .quo(qt_r));

	// stage 37: sign, zero forcing and output register
	sgn_t              sgn_o;
	logic              done_s37;
	logic [AXIS_W-1:0] lx_s37, ly_s37, rx_s37, ry_s37;
	logic [QUO_W-1:0]  lt_s37, rt_s37;

	assign sgn_o = sgn_dv_s[QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s37 <= 1'b0;
		end else begin
			done_s37 <= sgn_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		lx_s37 <= sgn_o.zero_l ? '0 :
			(sgn_o.sx_l ? AXIS_W'(-AXIS_W'(qx_l)) : AXIS_W'(qx_l));
		ly_s37 <= sgn_o.zero_l ? '0 :
			(sgn_o.sy_l ? AXIS_W'(-AXIS_W'(qy_l)) : AXIS_W'(qy_l));
		rx_s37 <= sgn_o.zero_r ? '0 :
			(sgn_o.sx_r ? AXIS_W'(-AXIS_W'(qx_r)) : AXIS_W'(qx_r));
		ry_s37 <= sgn_o.zero_r ? '0 :
			(sgn_o.sy_r ? AXIS_W'(-AXIS_W'(qy_r)) : AXIS_W'(qy_r));
		lt_s37 <= sgn_o.tz_l ? '0 : qt_l;
		rt_s37 <= sgn_o.tz_r ? '0 : qt_r;
	end

	assign done              = done_s37;
	assign left_out_x        = lx_s37;
	assign left_out_y        = ly_s37;
	assign right_out_x       = rx_s37;
	assign right_out_y       = ry_s37;
	assign left_trigger_out  = lt_s37;
	assign right_trigger_out = rt_s37;

	// every accepted sample leaves with a done pulse
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("sample did not complete after fixed latency");

	// rescaled stick axes never reach minus full scale
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (left_out_x != 16'sh8000) && (left_out_y != 16'sh8000))
		else $error("left stick output out of range");

	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (right_out_x != 16'sh8000) && (right_out_y != 16'sh8000))
		else $error("right stick output out of range");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gamepad dead zone normaliser. Directed corner
// samples run first, then randomised samples under several dead zone and
// trigger threshold settings. Each accepted sample is scored in order against
// its typed table row or a local model of radial dead zone and trigger rescale.
// ----------------------------------------------------------------------------
module testbench;
	import gdzn_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_DEPTH  = 37;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 450;
	localparam int NUM_PHASES  = 8;

	typedef struct {
		logic signed [AXIS_W-1:0] lx, ly, rx, ry;
		logic [TRIG_W-1:0]        lt, rt;
	} pad_in_t;

	typedef struct {
		logic signed [AXIS_W-1:0] lx, ly, rx, ry;
		logic [QUO_W-1:0]         lt, rt;
	} pad_out_t;

	typedef struct {
		pad_in_t  stim;
		bit       typed;
		pad_out_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [AXIS_W-1:0] left_stick_x = '0, left_stick_y = '0;
	logic signed [AXIS_W-1:0] right_stick_x = '0, right_stick_y = '0;
	logic [TRIG_W-1:0] left_trigger_raw = '0, right_trigger_raw = '0;
	logic signed [AXIS_W-1:0] left_out_x, left_out_y, right_out_x, right_out_y;
	logic [QUO_W-1:0] left_trigger_out, right_trigger_out;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [DZ_W-1:0] cfg_wdata = '0;

	int left_dz = LEFT_DZ_RST_I;
	int right_dz = RIGHT_DZ_RST_I;
	int trig_thr = 30;

	pad_out_t   pending_out[$];
	table_row_t corner_rows[$];
	int mismatches = 0;
	int cycles = 0;
	int sent = 0;
	int scored = 0;
	bit burst = 0;

	gamepad_dead_zone_normalizer DUT (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions outstanding",
				cycles, pending_out.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic void scale_stick(input int x, input int y, input int dz,
			output logic signed [AXIS_W-1:0] ox, output logic signed [AXIS_W-1:0] oy);
		longint ax, ay, sum, m, mc, num, den, qx, qy;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		sum = ax * ax + ay * ay;
		ox = '0;
		oy = '0;
		if (dz < 32767 && sum > longint'(dz) * dz) begin
			m   = root_floor(sum);
			mc  = (m > 32767) ? 32767 : m;
			num = (mc - dz) * 32767;
			den = m * (32767 - dz);
			qx  = ax * num / den;
			qy  = ay * num / den;
			ox  = AXIS_W'((x < 0) ? -qx : qx);
			oy  = AXIS_W'((y < 0) ? -qy : qy);
		end
	endfunction

	function automatic logic [QUO_W-1:0] scale_trigger(logic [TRIG_W-1:0] v);
		if (int'(v) <= trig_thr) return '0;
		return QUO_W'((int'(v) - trig_thr) * 32767 / (255 - trig_thr));
	endfunction

	function automatic pad_out_t normalise(pad_in_t s);
		pad_out_t r;
		scale_stick(s.lx, s.ly, left_dz, r.lx, r.ly);
		scale_stick(s.rx, s.ry, right_dz, r.rx, r.ry);
		r.lt = scale_trigger(s.lt);
		r.rt = scale_trigger(s.rt);
		return r;
	endfunction

	// score each strobed result against the oldest pending one
	always @(posedge clk) begin
		pad_out_t w;
		if (arst_n && done) begin
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at cycle %0d", cycles);
			end else begin
				w = pending_out.pop_front();
				scored++;
				if (w.lx !== left_out_x || w.ly !== left_out_y || w.rx !== right_out_x ||
						w.ry !== right_out_y || w.lt !== left_trigger_out ||
						w.rt !== right_trigger_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
							scored, w.lx, w.ly, w.rx, w.ry, w.lt, w.rt, left_out_x,
							left_out_y, right_out_x, right_out_y, left_trigger_out,
							right_trigger_out);
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = DZ_W'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LEFT_DZ:  left_dz = val & 32'h7fff;
			REG_RIGHT_DZ: right_dz = val & 32'h7fff;
			REG_TRIG_THR: trig_thr = val & 32'hff;
			default: ;
		endcase
	endtask

	// hold start until the transaction is taken, then queue its expectation
	task automatic send(input pad_in_t s, input bit typed, input pad_out_t want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		{left_stick_x, left_stick_y, right_stick_x, right_stick_y} = {s.lx, s.ly, s.rx, s.ry};
		left_trigger_raw = s.lt;
		right_trigger_raw = s.rt;
		do @(posedge clk); while (busy);
		pending_out.push_back(typed ? want : normalise(s));
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		start = 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [AXIS_W-1:0] pick_axis(int dz);
		int r;
		case ($urandom_range(0, 5))
			0, 1: return AXIS_W'($urandom);
			2: begin
				case ($urandom_range(0, 5))
					0: return -16'sd32768;
					1: return -16'sd32767;
					2: return 16'sd32767;
					3: return -16'sd1;
					4: return 16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: begin
				// land around the dead zone rim
				r = (dz > 32600) ? 32767 : dz + 160;
				return AXIS_W'(int'($urandom_range(0, 2 * r)) - r);
			end
		endcase
	endfunction

	function automatic logic [TRIG_W-1:0] pick_trigger();
		int v;
		if ($urandom_range(0, 2) == 0) begin
			v = trig_thr + int'($urandom_range(0, 2)) - 1;
			return TRIG_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
		end
		return TRIG_W'($urandom);
	endfunction

	task automatic add_row(input int lx, ly, rx, ry, lt, rt, input bit typed,
			input int elx, ely, erx, ery, elt, ert);
		table_row_t row;
		row.stim = '{AXIS_W'(lx), AXIS_W'(ly), AXIS_W'(rx), AXIS_W'(ry),
			TRIG_W'(lt), TRIG_W'(rt)};
		row.typed = typed;
		row.want = '{AXIS_W'(elx), AXIS_W'(ely), AXIS_W'(erx), AXIS_W'(ery),
			QUO_W'(elt), QUO_W'(ert)};
		corner_rows.push_back(row);
	endtask

	initial begin
		pad_in_t s;
		pad_out_t none;
		int phase_items;
		none = '{0, 0, 0, 0, 0, 0};
		// reset settings: left 7849, right 8689, threshold 30
		add_row(0, 0, 0, 0, 0, 30, 1, 0, 0, 0, 0, 0, 0);
		add_row(32767, 0, 0, -32768, 255, 31, 1, 32767, 0, 0, -32767, 32767, 145);
		add_row(-32768, 0, 32767, 0, 31, 255, 1, -32767, 0, 32767, 0, 145, 32767);
		add_row(7849, 0, 0, 8689, 30, 30, 1, 0, 0, 0, 0, 0, 0);
		add_row(0, -7849, -8689, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0);
		add_row(7850, 0, 0, 8690, 32, 254, 0, 0, 0, 0, 0, 0, 0);
		add_row(-32768, -32768, -32768, -32768, 128, 200, 0, 0, 0, 0, 0, 0, 0);
		add_row(32767, 32767, -32767, 32767, 100, 29, 0, 0, 0, 0, 0, 0, 0);
		add_row(23170, -23170, 6000, 6500, 60, 250, 0, 0, 0, 0, 0, 0, 0);
		add_row(-1, 32767, 1, -32767, 254, 2, 0, 0, 0, 0, 0, 0, 0);
		add_row(5551, 5551, 6144, -6144, 77, 170, 0, 0, 0, 0, 0, 0, 0);
		add_row(-16000, 28000, 21845, -21846, 255, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_rows[i])
			send(corner_rows[i].stim, corner_rows[i].typed, corner_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: ;
				1: begin write_reg(REG_LEFT_DZ, 0); write_reg(REG_RIGHT_DZ, 0);
					write_reg(REG_TRIG_THR, 0); end
				2: begin write_reg(REG_LEFT_DZ, 32767); write_reg(REG_RIGHT_DZ, 32766);
					write_reg(REG_TRIG_THR, 255); end
				3: begin write_reg(REG_LEFT_DZ, 32766); write_reg(REG_RIGHT_DZ, 32767);
					write_reg(REG_TRIG_THR, 254); end
				4: begin write_reg(REG_LEFT_DZ, 1); write_reg(REG_RIGHT_DZ, 100);
					write_reg(REG_TRIG_THR, 1); write_reg(REG_UNUSED, 32767); end
				default: begin
					write_reg(REG_LEFT_DZ, $urandom_range(0, 32767));
					write_reg(REG_RIGHT_DZ, $urandom_range(0, 32767));
					write_reg(REG_TRIG_THR, $urandom_range(0, 255));
				end
			endcase
			phase_items = RANDOM_ITEMS / NUM_PHASES;
			for (int n = 0; n < phase_items; n++) begin
				if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
				s.lx = pick_axis(left_dz);
				s.ly = pick_axis(left_dz);
				s.rx = pick_axis(right_dz);
				s.ry = pick_axis(right_dz);
				s.lt = pick_trigger();
				s.rt = pick_trigger();
				send(s, 0, none);
			end
		end
		burst = 0;
		drain();

		$display("%0d samples sent over %0d register settings, %0d results scored",
			sent, NUM_PHASES, scored);
		$display("%0d mismatches in %0d cycles", mismatches, cycles);
		if (mismatches == 0 && pending_out.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
